/* rtl/core/rpb_pkg.sv */
package rpb_pkg;

    // channel and weight widths
    localparam int CH_W     = 8;
    localparam int WGT_W    = 12;
    localparam int WFRAC_W  = 8;
    localparam int WPROD_W  = CH_W + WGT_W;
    localparam int MPROD_W  = 2 * CH_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [CH_W-1:0]  CH_MAX     = 8'hFF;
    localparam logic [WGT_W-1:0] WEIGHT_ONE = 12'd256;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_IDX_WA = 2'd0;
    localparam t_cfg_idx CFG_IDX_WB = 2'd1;

    // blend mode codes
    typedef enum logic [3:0] {
        FN_ADD   = 4'd0,
        FN_WGT   = 4'd1,
        FN_SUB   = 4'd2,
        FN_MUL   = 4'd3,
        FN_DIV   = 4'd4,
        FN_DIFF  = 4'd5,
        FN_MIN   = 4'd6,
        FN_MAX   = 4'd7,
        FN_ISECT = 4'd8,
        FN_AVG   = 4'd9,
        FN_MASK  = 4'd10
    } t_func;

    // per-pixel control shared by the three channels
    typedef struct packed {
        t_func func;
        logic  isect_black;
        logic  mask_pass;
    } t_pix_ctl;

    // one restoring division step: returns {quotient bit, new remainder}
    function automatic logic [CH_W:0] div_step(input logic [CH_W-1:0] rem,
                                               input logic            dvd_bit,
                                               input logic [CH_W-1:0] dvs);
        logic [CH_W:0] sh;
        logic [CH_W:0] diff;
        sh   = {rem, dvd_bit};
        diff = sh - {1'b0, dvs};
        if (sh >= {1'b0, dvs}) begin
            return {1'b1, diff[CH_W-1:0]};
        end else begin
            return {1'b0, sh[CH_W-1:0]};
        end
    endfunction

endpackage

/* rtl/core/rpb_chan.sv */
module rpb_chan (
    input  logic                       i_clk,
    input  rpb_pkg::t_pix_ctl          i_ctl,
    input  logic [rpb_pkg::CH_W-1:0]   i_a,
    input  logic [rpb_pkg::CH_W-1:0]   i_b,
    input  logic [rpb_pkg::WGT_W-1:0]  i_wa,
    input  logic [rpb_pkg::WGT_W-1:0]  i_wb,
    output logic [rpb_pkg::CH_W-1:0]   o_res
);
    import rpb_pkg::*;

    // stage 1 combinational
    logic [CH_W:0]      sum9;
    logic [CH_W-1:0]    add_sat;
    logic [CH_W-1:0]    simple;
    logic [CH_W:0]      d7;
    logic [CH_W:0]      d6;

    // stage 1 registers
    t_func              r_s1_func;
    logic [CH_W-1:0]    r_s1_a;
    logic [CH_W-1:0]    r_s1_b;
    logic [CH_W-1:0]    r_s1_simple;
    logic [WPROD_W-1:0] r_s1_pa;
    logic [WPROD_W-1:0] r_s1_pb;
    logic [MPROD_W-1:0] r_s1_pm;
    logic [CH_W-1:0]    r_s1_rem;
    logic [1:0]         r_s1_q;

    // stage 2
    logic [CH_W-1:0]    sa;
    logic [CH_W-1:0]    sb;
    logic [CH_W:0]      wsum;
    logic [CH_W-1:0]    res2;
    logic [CH_W:0]      d5;
    logic [CH_W:0]      d4;
    t_func              r_s2_func;
    logic [CH_W-1:0]    r_s2_a;
    logic [CH_W-1:0]    r_s2_b;
    logic [CH_W-1:0]    r_s2_res;
    logic [CH_W-1:0]    r_s2_rem;
    logic [3:0]         r_s2_q;

    // stage 3
    logic [CH_W:0]      d3;
    logic [CH_W:0]      d2;
    t_func              r_s3_func;
    logic [CH_W-1:0]    r_s3_a;
    logic [CH_W-1:0]    r_s3_b;
    logic [CH_W-1:0]    r_s3_res;
    logic [CH_W-1:0]    r_s3_rem;
    logic [5:0]         r_s3_q;

    // stage 4
    logic [CH_W:0]      d1;
    logic [CH_W:0]      d0;
    logic [CH_W-1:0]    n_res;
    logic [CH_W-1:0]    r_s4_res;

    // modes computed in stage 1, divider steps for bits 7 and 6
    always_comb begin
        sum9    = {1'b0, i_a} + {1'b0, i_b};
        add_sat = sum9[CH_W] ? CH_MAX : sum9[CH_W-1:0];
        case (i_ctl.func)
            FN_ADD:   simple = add_sat;
            FN_SUB:   simple = (i_a > i_b) ? i_a - i_b : '0;
            FN_DIFF:  simple = (i_a > i_b) ? i_a - i_b : i_b - i_a;
            FN_MIN:   simple = (i_a < i_b) ? i_a : i_b;
            FN_MAX:   simple = (i_a > i_b) ? i_a : i_b;
            FN_ISECT: simple = i_ctl.isect_black ? '0 : add_sat;
            FN_AVG:   simple = sum9[CH_W:1];
            FN_MASK:  simple = i_ctl.mask_pass ? i_a : '0;
            default:  simple = '0;
        endcase
        d7 = div_step('0, i_a[7], i_b);
        d6 = div_step(d7[CH_W-1:0], i_a[6], i_b);
    end

    always_ff @(posedge i_clk) begin
        r_s1_func   <= i_ctl.func;
        r_s1_a      <= i_a;
        r_s1_b      <= i_b;
        r_s1_simple <= simple;
        r_s1_pa     <= {{(WPROD_W-CH_W){1'b0}}, i_a} * {{(WPROD_W-WGT_W){1'b0}}, i_wa};
        r_s1_pb     <= {{(WPROD_W-CH_W){1'b0}}, i_b} * {{(WPROD_W-WGT_W){1'b0}}, i_wb};
        r_s1_pm     <= {{CH_W{1'b0}}, i_a} * {{CH_W{1'b0}}, i_b};
        r_s1_rem    <= d6[CH_W-1:0];
        r_s1_q      <= {d7[CH_W], d6[CH_W]};
    end

    // saturate the products, select weighted and multiply, bits 5 and 4
    always_comb begin
        sa   = (|r_s1_pa[WPROD_W-1:WFRAC_W+CH_W]) ? CH_MAX
                                                  : r_s1_pa[WFRAC_W+CH_W-1:WFRAC_W];
        sb   = (|r_s1_pb[WPROD_W-1:WFRAC_W+CH_W]) ? CH_MAX
                                                  : r_s1_pb[WFRAC_W+CH_W-1:WFRAC_W];
        wsum = {1'b0, sa} + {1'b0, sb};
        case (r_s1_func)
            FN_WGT:  res2 = wsum[CH_W] ? CH_MAX : wsum[CH_W-1:0];
            FN_MUL:  res2 = (|r_s1_pm[MPROD_W-1:CH_W]) ? CH_MAX : r_s1_pm[CH_W-1:0];
            default: res2 = r_s1_simple;
        endcase
        d5 = div_step(r_s1_rem, r_s1_a[5], r_s1_b);
        d4 = div_step(d5[CH_W-1:0], r_s1_a[4], r_s1_b);
    end

    always_ff @(posedge i_clk) begin
        r_s2_func <= r_s1_func;
        r_s2_a    <= r_s1_a;
        r_s2_b    <= r_s1_b;
        r_s2_res  <= res2;
        r_s2_rem  <= d4[CH_W-1:0];
        r_s2_q    <= {r_s1_q, d5[CH_W], d4[CH_W]};
    end

    // divider bits 3 and 2
    always_comb begin
        d3 = div_step(r_s2_rem, r_s2_a[3], r_s2_b);
        d2 = div_step(d3[CH_W-1:0], r_s2_a[2], r_s2_b);
    end

    always_ff @(posedge i_clk) begin
        r_s3_func <= r_s2_func;
        r_s3_a    <= r_s2_a;
        r_s3_b    <= r_s2_b;
        r_s3_res  <= r_s2_res;
        r_s3_rem  <= d2[CH_W-1:0];
        r_s3_q    <= {r_s2_q, d3[CH_W], d2[CH_W]};
    end

    // divider bits 1 and 0, divide by zero gives full scale
    always_comb begin
        d1 = div_step(r_s3_rem, r_s3_a[1], r_s3_b);
        d0 = div_step(d1[CH_W-1:0], r_s3_a[0], r_s3_b);
        if (r_s3_func == FN_DIV) begin
            n_res = (r_s3_b == '0) ? CH_MAX : {r_s3_q, d1[CH_W], d0[CH_W]};
        end else begin
            n_res = r_s3_res;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_res <= n_res;
    end

    assign o_res = r_s4_res;

endmodule

/* rtl/core/rgb_pixel_blend_unit.sv */
// a pixel accepted at a clock edge is registered in stage 1, moves through stages 2
// and 3 into the fourth register stage and sits on the outputs with o_strobe
// throughput: one pixel per clock; the divider is unrolled two bits per stage
// busy stays low and the receiver cannot stall, so nothing ever waits
// reset clears the valid pipeline and sets both weights to 1.0 (256)
module rgb_pixel_blend_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cfg_we,
    input  rpb_pkg::t_cfg_idx             i_cfg_idx,
    input  logic [rpb_pkg::WGT_W-1:0]     i_cfg_wdata,
    input  logic [3:0]                    i_func,
    input  logic [rpb_pkg::CH_W-1:0]      i_a_red,
    input  logic [rpb_pkg::CH_W-1:0]      i_a_green,
    input  logic [rpb_pkg::CH_W-1:0]      i_a_blue,
    input  logic [rpb_pkg::CH_W-1:0]      i_b_red,
    input  logic [rpb_pkg::CH_W-1:0]      i_b_green,
    input  logic [rpb_pkg::CH_W-1:0]      i_b_blue,
    output logic                          o_strobe,
    output logic [rpb_pkg::CH_W-1:0]      o_out_red,
    output logic [rpb_pkg::CH_W-1:0]      o_out_green,
    output logic [rpb_pkg::CH_W-1:0]      o_out_blue
);
    import rpb_pkg::*;

    localparam int NSTAGE = 4;

    logic [WGT_W-1:0]  r_weight_a;
    logic [WGT_W-1:0]  r_weight_b;
    logic [WGT_W-1:0]  n_weight_a;
    logic [WGT_W-1:0]  n_weight_b;
    logic [NSTAGE-1:0] r_valid;
    logic [NSTAGE-1:0] n_valid;
    logic              accept;
    t_pix_ctl          ctl;

    // the pipeline never stalls
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // weight registers
    always_comb begin
        n_weight_a = r_weight_a;
        n_weight_b = r_weight_b;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IDX_WA: n_weight_a = i_cfg_wdata;
                CFG_IDX_WB: n_weight_b = i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // valid bits travel alongside the channel data
    assign n_valid = {r_valid[NSTAGE-2:0], accept};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight_a <= WEIGHT_ONE;
            r_weight_b <= WEIGHT_ONE;
            r_valid    <= '0;
        end else begin
            r_weight_a <= n_weight_a;
            r_weight_b <= n_weight_b;
            r_valid    <= n_valid;
        end
    end

    // whole-pixel conditions for intersect and mask
    always_comb begin
        ctl.func        = t_func'(i_func);
        ctl.isect_black = ((i_a_red | i_a_green | i_a_blue) == '0) ||
                          ((i_b_red | i_b_green | i_b_blue) == '0);
        ctl.mask_pass   = (i_b_red != '0) && (i_b_green != '0) && (i_b_blue != '0);
    end

    rpb_chan u_chan_red (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_a   (i_a_red),
        .i_b   (i_b_red),
        .i_wa  (r_weight_a),
        .i_wb  (r_weight_b),
        .o_res (o_out_red)
    );

    rpb_chan u_chan_green (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_a   (i_a_green),
        .i_b   (i_b_green),
        .i_wa  (r_weight_a),
        .i_wb  (r_weight_b),
        .o_res (o_out_green)
    );

    rpb_chan u_chan_blue (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_a   (i_a_blue),
        .i_b   (i_b_blue),
        .i_wa  (r_weight_a),
        .i_wb  (r_weight_b),
        .o_res (o_out_blue)
    );

    assign o_strobe = r_valid[NSTAGE-1];

    // every accepted transaction produces a strobe
    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##4 o_strobe)
        else $error("accepted pixel did not produce a strobe");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, 4))
        else $error("strobe without an accepted pixel");

    // divide by zero saturates the red channel
    a_div_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_func == FN_DIV) && (i_b_red == '0) |-> ##4 (o_out_red == CH_MAX))
        else $error("divide by zero did not saturate");

    // red min never exceeds its first operand
    a_min_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_func == FN_MIN) |-> ##4 (o_out_red <= $past(i_a_red, 4)))
        else $error("min result larger than operand");

endmodule

/* verif/rgb_pixel_blend_unit_test.sv */
module rgb_pixel_blend_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rpb_pkg::*;

    // codes outside the defined blend modes and register map
    localparam logic [3:0] FN_UNDEF_LO      = 4'd11;
    localparam logic [3:0] FN_UNDEF_HI      = 4'd15;
    localparam t_cfg_idx   CFG_IDX_SPARE_LO = 2'd2;
    localparam t_cfg_idx   CFG_IDX_SPARE_HI = 2'd3;

    localparam logic [WGT_W-1:0] WGT_ZERO = '0;
    localparam logic [WGT_W-1:0] WGT_FULL = '1;

    localparam int QUIET_LIMIT  = 2000;
    localparam int CHUNK_ITEMS  = 170;
    localparam int CHUNKS       = 4;
    localparam int DRAIN_CYCLES = 8;

    typedef logic [CH_W-1:0] chan_t;
    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } rgb_t;

    typedef struct {
        logic [3:0] func;
        rgb_t       a;
        rgb_t       b;
        bit         fixed;
        rgb_t       want;
    } stim_row_t;

    localparam rgb_t WHITE = {8'd255, 8'd255, 8'd255};
    localparam rgb_t BLACK = {8'd0, 8'd0, 8'd0};

    logic              i_clk;
    logic              i_rst_n     = 1'b0;
    logic              start       = 1'b0;
    logic              busy;
    logic              i_cfg_we    = 1'b0;
    t_cfg_idx          i_cfg_idx   = CFG_IDX_WA;
    logic [WGT_W-1:0]  i_cfg_wdata = '0;
    logic [3:0]        i_func      = '0;
    chan_t             i_a_red     = '0;
    chan_t             i_a_green   = '0;
    chan_t             i_a_blue    = '0;
    chan_t             i_b_red     = '0;
    chan_t             i_b_green   = '0;
    chan_t             i_b_blue    = '0;
    logic              o_strobe;
    chan_t             o_out_red;
    chan_t             o_out_green;
    chan_t             o_out_blue;

    // model copy of the weight registers
    logic [WGT_W-1:0]  mdl_weight_a = WEIGHT_ONE;
    logic [WGT_W-1:0]  mdl_weight_b = WEIGHT_ONE;

    rgb_t              pending_pixels[$];
    stim_row_t         dir_rows[$];
    int                err_count    = 0;
    int                quiet_cycles = 0;

    rgb_pixel_blend_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_func      (i_func),
        .i_a_red     (i_a_red),
        .i_a_green   (i_a_green),
        .i_a_blue    (i_a_blue),
        .i_b_red     (i_b_red),
        .i_b_green   (i_b_green),
        .i_b_blue    (i_b_blue),
        .o_strobe    (o_strobe),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // clamp to the channel range
    function automatic chan_t clamp_chan(int unsigned v);
        return (v > int'(CH_MAX)) ? CH_MAX : chan_t'(v);
    endfunction

    // one channel of the per-channel modes
    function automatic chan_t blend_chan(logic [3:0] func, chan_t a, chan_t b,
                                         logic [WGT_W-1:0] wa, logic [WGT_W-1:0] wb);
        int unsigned ua;
        int unsigned ub;
        int unsigned term_a;
        int unsigned term_b;
        ua     = a;
        ub     = b;
        term_a = clamp_chan((ua * wa) >> WFRAC_W);
        term_b = clamp_chan((ub * wb) >> WFRAC_W);
        case (func)
            FN_ADD:  return clamp_chan(ua + ub);
            FN_WGT:  return clamp_chan(term_a + term_b);
            FN_SUB:  return (a > b) ? chan_t'(a - b) : '0;
            FN_MUL:  return clamp_chan(ua * ub);
            FN_DIV:  return (b == '0) ? CH_MAX : chan_t'(ua / ub);
            FN_DIFF: return (a > b) ? chan_t'(a - b) : chan_t'(b - a);
            FN_MIN:  return (a < b) ? a : b;
            FN_MAX:  return (a > b) ? a : b;
            FN_AVG:  return chan_t'((ua + ub) >> 1);
            default: return '0;
        endcase
    endfunction

    // whole-pixel blend, intersect and mask look at all three channels
    function automatic rgb_t blend_pixel(logic [3:0] func, rgb_t a, rgb_t b,
                                         logic [WGT_W-1:0] wa, logic [WGT_W-1:0] wb);
        rgb_t r;
        logic a_black;
        logic b_black;
        logic b_full;
        a_black = (a == BLACK);
        b_black = (b == BLACK);
        b_full  = (b.red != '0) && (b.green != '0) && (b.blue != '0);
        if (func == FN_ISECT) begin
            if (a_black || b_black) begin
                r = BLACK;
            end else begin
                r.red   = blend_chan(FN_ADD, a.red, b.red, wa, wb);
                r.green = blend_chan(FN_ADD, a.green, b.green, wa, wb);
                r.blue  = blend_chan(FN_ADD, a.blue, b.blue, wa, wb);
            end
        end else if (func == FN_MASK) begin
            r = b_full ? a : BLACK;
        end else begin
            r.red   = blend_chan(func, a.red, b.red, wa, wb);
            r.green = blend_chan(func, a.green, b.green, wa, wb);
            r.blue  = blend_chan(func, a.blue, b.blue, wa, wb);
        end
        return r;
    endfunction

    // channel values weighted toward the edges of the range
    function automatic chan_t rand_chan();
        case ($urandom_range(9))
            0:       return '0;
            1:       return CH_MAX;
            2:       return chan_t'($urandom_range(3, 1));
            default: return chan_t'($urandom);
        endcase
    endfunction

    function automatic rgb_t rand_pixel();
        rgb_t p;
        if ($urandom_range(9) == 0) begin
            p = BLACK;
        end else begin
            p.red   = rand_chan();
            p.green = rand_chan();
            p.blue  = rand_chan();
        end
        return p;
    endfunction

    function automatic logic [3:0] rand_func();
        if ($urandom_range(19) == 0) begin
            return 4'($urandom_range(int'(FN_UNDEF_HI), int'(FN_UNDEF_LO)));
        end else begin
            return 4'($urandom_range(int'(FN_MASK), int'(FN_ADD)));
        end
    endfunction

    task automatic add_row(logic [3:0] func, rgb_t a, rgb_t b, bit fixed, rgb_t want);
        stim_row_t row;
        row.func  = func;
        row.a     = a;
        row.b     = b;
        row.fixed = fixed;
        row.want  = want;
        dir_rows.push_back(row);
    endtask

    // present one pixel pair and hold it until it is accepted
    task automatic send_pixel(logic [3:0] func, rgb_t a, rgb_t b, bit fixed, rgb_t want);
        start     <= 1'b1;
        i_func    <= func;
        i_a_red   <= a.red;
        i_a_green <= a.green;
        i_a_blue  <= a.blue;
        i_b_red   <= b.red;
        i_b_green <= b.green;
        i_b_blue  <= b.blue;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        if (fixed) begin
            pending_pixels.push_back(want);
        end else begin
            pending_pixels.push_back(blend_pixel(func, a, b, mdl_weight_a, mdl_weight_b));
        end
    endtask

    // random sender gaps
    task automatic sender_gap(int pct);
        while ($urandom_range(99) < pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // stop sending until every outstanding pixel has come back
    task automatic drain();
        start <= 1'b0;
        while (pending_pixels.size() != 0) begin
            @(posedge i_clk);
        end
        @(posedge i_clk);
    endtask

    // weight writes, only while the pipeline is empty
    task automatic load_weights(logic [WGT_W-1:0] wa, logic [WGT_W-1:0] wb, bit spare);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_IDX_WA;
        i_cfg_wdata <= wa;
        @(posedge i_clk);
        mdl_weight_a = wa;
        i_cfg_idx   <= CFG_IDX_WB;
        i_cfg_wdata <= wb;
        @(posedge i_clk);
        mdl_weight_b = wb;
        if (spare) begin
            // unmapped index, must leave both weights alone
            i_cfg_idx   <= ($urandom_range(1) != 0) ? CFG_IDX_SPARE_HI : CFG_IDX_SPARE_LO;
            i_cfg_wdata <= WGT_W'($urandom);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin : chk_blk
        rgb_t want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (pending_pixels.size() == 0) begin
                $error("result with no pending pixel: %0d %0d %0d",
                       o_out_red, o_out_green, o_out_blue);
                err_count++;
            end else begin
                want = pending_pixels.pop_front();
                if (o_out_red !== want.red) begin
                    $error("out_red expected %0d actual %0d", want.red, o_out_red);
                    err_count++;
                end
                if (o_out_green !== want.green) begin
                    $error("out_green expected %0d actual %0d", want.green, o_out_green);
                    err_count++;
                end
                if (o_out_blue !== want.blue) begin
                    $error("out_blue expected %0d actual %0d", want.blue, o_out_blue);
                    err_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction either side
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_strobe === 1'b1) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT - 1) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus
    initial begin : stim_blk
        int               idle_pct;
        int               k;
        logic [WGT_W-1:0] wa;
        logic [WGT_W-1:0] wb;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows at the reset weights
        add_row(FN_ADD,  WHITE, WHITE, 1, WHITE);
        add_row(FN_ADD,  BLACK, BLACK, 1, BLACK);
        add_row(FN_WGT,  WHITE, WHITE, 1, WHITE);
        add_row(FN_WGT,  {8'd200, 8'd1, 8'd128}, {8'd100, 8'd0, 8'd127}, 0, BLACK);
        add_row(FN_SUB,  BLACK, WHITE, 1, BLACK);
        add_row(FN_SUB,  WHITE, BLACK, 1, WHITE);
        add_row(FN_MUL,  WHITE, WHITE, 1, WHITE);
        add_row(FN_MUL,  BLACK, WHITE, 1, BLACK);
        add_row(FN_MUL,  {8'd15, 8'd16, 8'd1}, {8'd17, 8'd16, 8'd200}, 0, BLACK);
        add_row(FN_DIV,  {8'd200, 8'd0, 8'd255}, BLACK, 1, WHITE);
        add_row(FN_DIV,  {8'd255, 8'd7, 8'd100}, {8'd1, 8'd2, 8'd255}, 0, BLACK);
        add_row(FN_DIFF, {8'd0, 8'd255, 8'd10}, {8'd255, 8'd0, 8'd10}, 1,
                {8'd255, 8'd255, 8'd0});
        add_row(FN_MIN,  {8'd0, 8'd255, 8'd10}, {8'd255, 8'd0, 8'd11}, 1,
                {8'd0, 8'd0, 8'd10});
        add_row(FN_MAX,  {8'd0, 8'd255, 8'd10}, {8'd255, 8'd0, 8'd11}, 1,
                {8'd255, 8'd255, 8'd11});
        add_row(FN_ISECT, BLACK, WHITE, 1, BLACK);
        add_row(FN_ISECT, {8'd1, 8'd2, 8'd3}, BLACK, 1, BLACK);
        add_row(FN_ISECT, {8'd200, 8'd1, 8'd0}, {8'd100, 8'd0, 8'd5}, 0, BLACK);
        add_row(FN_AVG,  WHITE, WHITE, 1, WHITE);
        add_row(FN_AVG,  {8'd255, 8'd0, 8'd1}, BLACK, 0, BLACK);
        add_row(FN_MASK, {8'd12, 8'd34, 8'd56}, {8'd1, 8'd255, 8'd1}, 0, BLACK);
        add_row(FN_MASK, WHITE, {8'd1, 8'd0, 8'd1}, 1, BLACK);
        add_row(FN_UNDEF_LO, WHITE, WHITE, 1, BLACK);
        add_row(FN_UNDEF_HI, WHITE, WHITE, 1, BLACK);

        foreach (dir_rows[i]) begin
            send_pixel(dir_rows[i].func, dir_rows[i].a, dir_rows[i].b,
                       dir_rows[i].fixed, dir_rows[i].want);
        end

        // random part: three idling profiles, weights changed between chunks
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       idle_pct = 6;
                1:       idle_pct = 78;
                default: idle_pct = 0;
            endcase
            for (int chunk = 0; chunk < CHUNKS; chunk++) begin
                k = phase * CHUNKS + chunk;
                case (k % 6)
                    0: begin wa = WGT_ZERO; wb = WGT_ZERO; end
                    1: begin wa = WGT_FULL; wb = WGT_FULL; end
                    2: begin wa = WGT_ZERO; wb = WGT_FULL; end
                    3: begin wa = WGT_FULL; wb = WGT_ZERO; end
                    4: begin wa = WEIGHT_ONE >> 1; wb = WEIGHT_ONE + (WEIGHT_ONE >> 1); end
                    default: begin wa = WGT_W'($urandom); wb = WGT_W'($urandom); end
                endcase
                drain();
                load_weights(wa, wb, (k % 3) == 0);
                for (int n = 0; n < CHUNK_ITEMS; n++) begin
                    send_pixel(rand_func(), rand_pixel(), rand_pixel(), 0, BLACK);
                    sender_gap(idle_pct);
                end
            end
        end

        // wait for the tail of the pipeline
        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
